FILE: hw/rtl/bfa_pkg.sv
package bfa_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_RELEASE  = 2'd1;
    localparam logic [1:0] MODE_RESERVE  = 2'd2;
    localparam logic [1:0] MODE_MARK_ALL = 2'd3;

    // Result status carried on the output tuser.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NONE_FREE = 2'd1;
    localparam logic [1:0] ST_BEYOND    = 2'd2;
    localparam logic [1:0] ST_SAME      = 2'd3;

    // Each summary word holds one "not full" bit per map word.
    localparam int SUM_BITS = 32;
    localparam int SBIT_W   = $clog2(SUM_BITS);

    localparam logic [15:0] LIMIT_RESET = 16'd32768;

    typedef struct packed {
        logic map_rd;
        logic map_wr;
        logic sum_rd;
        logic sum_wr;
    } bfa_mem_cmd_t;

endpackage

FILE: hw/rtl/bfa_store.sv
module bfa_store #(
    parameter int MAP_WORDS = 1024,
    parameter int WORD_BITS = 32,
    parameter int SUM_WORDS = 32
) (
    input  logic                                        clk,
    input  bfa_pkg::bfa_mem_cmd_t                       cmd,
    input  logic [((MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1)-1:0] map_addr,
    input  logic [WORD_BITS-1:0]                        map_wdata,
    output logic [WORD_BITS-1:0]                        map_rdata,
    input  logic [((SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1)-1:0] sum_addr,
    input  logic [bfa_pkg::SUM_BITS-1:0]                sum_wdata,
    output logic [bfa_pkg::SUM_BITS-1:0]                sum_rdata
);
    import bfa_pkg::*;

    // The used map, one bit per frame, and the summary of words with a free frame.
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [SUM_BITS-1:0]  sum_mem [SUM_WORDS];

    always_ff @(posedge clk)
    begin
        if (cmd.map_wr)
        begin
            map_mem[map_addr] <= map_wdata;
        end
        if (cmd.map_rd)
        begin
            map_rdata <= map_mem[map_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_wr)
        begin
            sum_mem[sum_addr] <= sum_wdata;
        end
        if (cmd.sum_rd)
        begin
            sum_rdata <= sum_mem[sum_addr];
        end
    end

endmodule

FILE: hw/rtl/bitmap_frame_allocator.sv
// First-fit bitmap frame allocator.
// Requests arrive on s_axis: tuser carries the mode (allocate, release, reserve,
// mark all) and tdata the byte address used by release and reserve. Every request
// gives exactly one result on m_axis: tuser carries the status, tdata the allocated
// frame address, the used frame count and the free bytes below the limit.
// The map lives in a single-port word memory with a second memory that keeps one
// "word not full" bit per map word, plus a flop vector marking summary words that
// are nonzero. Allocate walks these three levels through LOOK, FIND and MODIFY, and
// the result is registered from DONE; the next request is taken back in IDLE.
// Release and reserve take a read-modify-write of map and summary in LOOK and MODIFY.
// A refused allocate or an address beyond the store goes from LOOK straight to DONE.
// Mark all rewrites every map word, one per cycle, in SWEEP and then gives its result
// from DONE. After reset the same pass runs with s_axis_tready low and leaves every
// frame used. cfg_we writes the block limit at any time; the block expects it only
// while idle. One finished result can wait in the output register while the next
// request is taken and worked on; that request then holds until the receiver takes
// the waiting result.
// BLOCK_BYTES and MAP_WORD_BITS are powers of two.
module bitmap_frame_allocator #(
    parameter int NUM_BLOCKS    = 32768,
    parameter int BLOCK_BYTES   = 4096,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] address
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [26:0] block_address, [42:27] used_count,
                                        // [70:43] free_bytes, [71] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import bfa_pkg::*;

    localparam int BIT_W       = $clog2(MAP_WORD_BITS);
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int MAP_WORDS   = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int SUM_WORDS   = (MAP_WORDS + SUM_BITS - 1) / SUM_BITS;
    localparam int WIDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SIDX_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int USED_W      = $clog2(NUM_BLOCKS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_FIND   = 3'd2;
    localparam logic [2:0] S_MODIFY = 3'd3;
    localparam logic [2:0] S_SWEEP  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           mode_reg;
    logic [31:0]          addr_reg;
    logic [SIDX_W-1:0]    sidx_reg;
    logic [SBIT_W-1:0]    sbit_reg;
    logic [WIDX_W-1:0]    widx_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [WIDX_W-1:0]    cnt_reg;
    logic                 sweep_init_reg;
    logic [SUM_WORDS-1:0] top_reg;
    logic [USED_W-1:0]    used_reg;
    logic [15:0]          limit_reg;
    logic [1:0]           res_status_reg;
    logic [26:0]          res_baddr_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [26:0]          out_baddr_reg;
    logic [15:0]          out_used_reg;
    logic [27:0]          out_free_reg;

    bfa_mem_cmd_t         mem_cmd;
    logic [WIDX_W-1:0]    map_addr;
    logic [MAP_WORD_BITS-1:0] map_wdata, map_rdata;
    logic [SIDX_W-1:0]    sum_addr;
    logic [SUM_BITS-1:0]  sum_wdata, sum_rdata;

    // Address decode for release and reserve.
    logic [31:0]          frame32, word32, sword32, cnt32, used32, limit32;
    logic                 beyond;
    logic [WIDX_W-1:0]    rr_widx;
    logic [SIDX_W-1:0]    rr_sidx;
    logic [SBIT_W-1:0]    rr_sbit;
    logic [BIT_W-1:0]     rr_bit;

    // Search results of the three levels.
    logic                 top_any;
    logic [SIDX_W-1:0]    top_idx;
    logic [SBIT_W-1:0]    sum_idx;
    logic [31:0]          alloc_word32;
    logic [WIDX_W-1:0]    alloc_widx;
    logic [BIT_W-1:0]     free_bit;

    // Read-modify-write of the selected word.
    logic [BIT_W-1:0]         use_bit;
    logic [MAP_WORD_BITS-1:0] bit_mask, new_word;
    logic                     want_used, same_state, new_full;
    logic [SUM_BITS-1:0]      new_sum;
    logic [31:0]              alloc_frame32;
    logic [63:0]              alloc_bytes;
    logic [31:0]              bound32, free32;
    logic [63:0]              free_bytes64;

    assign frame32 = addr_reg >> BLOCK_SHIFT;
    assign beyond  = frame32 >= 32'(NUM_BLOCKS);
    assign word32  = frame32 >> BIT_W;
    assign sword32 = word32 >> SBIT_W;
    assign rr_widx = word32[WIDX_W-1:0];
    assign rr_sidx = sword32[SIDX_W-1:0];
    assign rr_sbit = word32[SBIT_W-1:0];
    assign rr_bit  = frame32[BIT_W-1:0];
    assign cnt32   = 32'(cnt_reg);
    assign used32  = 32'(used_reg);
    assign limit32 = 32'(limit_reg);

    always_comb
    begin
        top_any = |top_reg;
        top_idx = '0;
        for (int i = SUM_WORDS - 1; i >= 0; i--)
        begin
            if (top_reg[i])
            begin
                top_idx = SIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        sum_idx = '0;
        for (int i = SUM_BITS - 1; i >= 0; i--)
        begin
            if (sum_rdata[i])
            begin
                sum_idx = SBIT_W'(i);
            end
        end
    end

    always_comb
    begin
        free_bit = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (!map_rdata[i])
            begin
                free_bit = BIT_W'(i);
            end
        end
    end

    assign alloc_word32 = (32'(sidx_reg) << SBIT_W) | 32'(sum_idx);
    assign alloc_widx   = alloc_word32[WIDX_W-1:0];

    always_comb
    begin
        use_bit    = (mode_reg == MODE_ALLOC) ? free_bit : bit_reg;
        bit_mask   = MAP_WORD_BITS'(1) << use_bit;
        want_used  = (mode_reg != MODE_RELEASE);
        same_state = (map_rdata[use_bit] == want_used);
        new_word   = want_used ? (map_rdata | bit_mask) : (map_rdata & ~bit_mask);
        new_full   = &new_word;
        new_sum    = sum_rdata;
        new_sum[sbit_reg] = !new_full;
    end

    assign alloc_frame32 = (32'(widx_reg) << BIT_W) | 32'(free_bit);
    assign alloc_bytes   = 64'(alloc_frame32) << BLOCK_SHIFT;

    assign bound32      = (limit32 < 32'(NUM_BLOCKS)) ? limit32 : 32'(NUM_BLOCKS);
    assign free32       = (used32 < bound32) ? (bound32 - used32) : 32'd0;
    assign free_bytes64 = 64'(free32) << BLOCK_SHIFT;

    // Memory port control.
    always_comb
    begin
        mem_cmd   = '0;
        map_addr  = widx_reg;
        sum_addr  = sidx_reg;
        map_wdata = new_word;
        sum_wdata = new_sum;
        unique case (state_reg)
            S_SWEEP:
            begin
                mem_cmd.map_wr = 1'b1;
                mem_cmd.sum_wr = cnt32 < 32'(SUM_WORDS);
                map_addr  = cnt_reg;
                sum_addr  = cnt32[SIDX_W-1:0];
                map_wdata = '1;
                sum_wdata = '0;
            end
            S_LOOK:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    mem_cmd.sum_rd = 1'b1;
                    sum_addr = top_idx;
                end
                else if (mode_reg != MODE_MARK_ALL)
                begin
                    mem_cmd.map_rd = 1'b1;
                    mem_cmd.sum_rd = 1'b1;
                    map_addr = rr_widx;
                    sum_addr = rr_sidx;
                end
            end
            S_FIND:
            begin
                mem_cmd.map_rd = 1'b1;
                map_addr = alloc_widx;
            end
            S_MODIFY:
            begin
                mem_cmd.map_wr = !same_state;
                mem_cmd.sum_wr = !same_state;
            end
            default:
            begin
            end
        endcase
    end

    bfa_store #(
        .MAP_WORDS (MAP_WORDS),
        .WORD_BITS (MAP_WORD_BITS),
        .SUM_WORDS (SUM_WORDS)
    ) u_store (
        .clk       (clk),
        .cmd       (mem_cmd),
        .map_addr  (map_addr),
        .map_wdata (map_wdata),
        .map_rdata (map_rdata),
        .sum_addr  (sum_addr),
        .sum_wdata (sum_wdata),
        .sum_rdata (sum_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                priority if (mode_reg == MODE_MARK_ALL)
                begin
                    state_next = S_SWEEP;
                end
                else if (mode_reg == MODE_ALLOC)
                begin
                    state_next = (used32 >= limit32 || !top_any) ? S_DONE : S_FIND;
                end
                else
                begin
                    state_next = beyond ? S_DONE : S_MODIFY;
                end
            end
            S_FIND:   state_next = S_MODIFY;
            S_MODIFY: state_next = S_DONE;
            S_SWEEP:
            begin
                if (cnt32 == 32'(MAP_WORDS - 1))
                begin
                    state_next = sweep_init_reg ? S_IDLE : S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            cnt_reg        <= '0;
            sweep_init_reg <= 1'b1;
            top_reg        <= '0;
            used_reg       <= USED_W'(NUM_BLOCKS);
            limit_reg      <= LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end

            if (state_reg == S_LOOK && mode_reg == MODE_MARK_ALL)
            begin
                cnt_reg        <= '0;
                sweep_init_reg <= 1'b0;
            end
            if (state_reg == S_SWEEP)
            begin
                cnt_reg <= cnt_reg + WIDX_W'(1);
                if (cnt32 == 32'(MAP_WORDS - 1))
                begin
                    top_reg  <= '0;
                    used_reg <= USED_W'(NUM_BLOCKS);
                end
            end

            if (state_reg == S_MODIFY && !same_state)
            begin
                top_reg[sidx_reg] <= |new_sum;
                if (want_used)
                begin
                    used_reg <= used_reg + USED_W'(1);
                end
                else if (used_reg != '0)
                begin
                    used_reg <= used_reg - USED_W'(1);
                end
            end

            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            mode_reg       <= s_axis_tuser;
            addr_reg       <= s_axis_tdata;
            res_status_reg <= ST_DONE;
            res_baddr_reg  <= '0;
        end

        if (state_reg == S_LOOK)
        begin
            if (mode_reg == MODE_ALLOC)
            begin
                sidx_reg <= top_idx;
                if (used32 >= limit32 || !top_any)
                begin
                    res_status_reg <= ST_NONE_FREE;
                end
            end
            else
            begin
                sidx_reg <= rr_sidx;
                sbit_reg <= rr_sbit;
                widx_reg <= rr_widx;
                bit_reg  <= rr_bit;
                if (mode_reg != MODE_MARK_ALL && beyond)
                begin
                    res_status_reg <= ST_BEYOND;
                end
            end
        end

        if (state_reg == S_FIND)
        begin
            sbit_reg <= sum_idx;
            widx_reg <= alloc_widx;
        end

        if (state_reg == S_MODIFY)
        begin
            if (same_state)
            begin
                res_status_reg <= ST_SAME;
            end
            else if (mode_reg == MODE_ALLOC)
            begin
                res_baddr_reg <= alloc_bytes[26:0];
            end
        end

        if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
        begin
            out_status_reg <= res_status_reg;
            out_baddr_reg  <= res_baddr_reg;
            out_used_reg   <= used32[15:0];
            out_free_reg   <= free_bytes64[27:0];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_free_reg, out_used_reg, out_baddr_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

FILE: dv/tb_bitmap_frame_allocator.sv
module tb_bitmap_frame_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int NUM_BLOCKS      = 32768;
    localparam int BLOCK_BYTES     = 4096;
    localparam int WORD_BITS       = 32;
    localparam int MAP_WORDS       = NUM_BLOCKS / WORD_BITS;
    localparam int HOLD_CYCLES     = 500;
    localparam int WATCHDOG_CYCLES = 8000;
    localparam int WINDOW_FRAMES   = 256;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] addr;
    } frame_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [26:0] block_address;
        logic [15:0] used_count;
        logic [27:0] free_bytes;
    } frame_reply_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] address
    logic [1:0]  s_axis_tuser  = MODE_ALLOC;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;   // [26:0] block_address, [42:27] used_count,
                                 // [70:43] free_bytes, [71] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        cfg_we        = 1'b0;
    logic [15:0] cfg_wdata     = '0;

    bitmap_frame_allocator #(
        .NUM_BLOCKS   (NUM_BLOCKS),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .MAP_WORD_BITS(WORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // Shadow copy of the frame map, the used count and the limit register.
    logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
    int unsigned          used_total;
    int unsigned          frame_limit;

    frame_request_t request_backlog[$];
    frame_reply_t   awaited_replies[$];

    bit          req_taken;
    bit          calm_phase;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned hold_asked;
    int unsigned hold_served;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned requests_taken;
    int unsigned replies_checked;
    int unsigned mark_all_taken;
    int unsigned limit_writes;
    int unsigned status_seen [4];

    function automatic frame_reply_t apply_request(logic [1:0] mode, logic [31:0] addr);
        frame_reply_t reply;
        int unsigned  frame;
        int unsigned  bound;
        int unsigned  w;
        int unsigned  b;
        bit           found;
        bit           want_used;

        reply = '0;
        reply.status = ST_DONE;
        case (mode)
            MODE_ALLOC:
            begin
                found = 1'b0;
                if (used_total < frame_limit) begin
                    for (w = 0; w < MAP_WORDS && !found; w++) begin
                        if (frame_map[w] != '1) begin
                            for (b = 0; b < WORD_BITS && !found; b++) begin
                                if (!frame_map[w][b]) begin
                                    frame = w * WORD_BITS + b;
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                end
                if (!found) begin
                    reply.status = ST_NONE_FREE;
                end else begin
                    frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
                    used_total++;
                    reply.block_address = 27'(frame * BLOCK_BYTES);
                end
            end
            MODE_RELEASE, MODE_RESERVE:
            begin
                frame = addr / BLOCK_BYTES;
                want_used = (mode == MODE_RESERVE);
                if (frame >= NUM_BLOCKS) begin
                    reply.status = ST_BEYOND;
                end else if (frame_map[frame / WORD_BITS][frame % WORD_BITS] == want_used) begin
                    reply.status = ST_SAME;
                end else begin
                    frame_map[frame / WORD_BITS][frame % WORD_BITS] = want_used;
                    if (want_used)
                        used_total++;
                    else if (used_total > 0)
                        used_total--;
                end
            end
            default:
            begin
                foreach (frame_map[i])
                    frame_map[i] = '1;
                used_total = NUM_BLOCKS;
            end
        endcase

        bound = (frame_limit < NUM_BLOCKS) ? frame_limit : NUM_BLOCKS;
        reply.used_count = 16'(used_total);
        reply.free_bytes = (used_total < bound) ? 28'((bound - used_total) * BLOCK_BYTES) : '0;
        return reply;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Most addresses land in a small window so that allocation and release meet.
    function automatic logic [31:0] pick_address();
        int unsigned r;
        int unsigned offset;

        r = $urandom_range(0, 99);
        offset = $urandom_range(0, BLOCK_BYTES - 1);
        if (r < 75)
            return $urandom_range(0, WINDOW_FRAMES - 1) * BLOCK_BYTES + offset;
        if (r < 90)
            return $urandom_range(0, NUM_BLOCKS - 1) * BLOCK_BYTES + offset;
        return $urandom_range(NUM_BLOCKS, 32'hFFFFF) * BLOCK_BYTES + offset;
    endfunction

    task automatic queue_request(input logic [1:0] mode, input logic [31:0] addr);
        frame_request_t req;

        req.mode = mode;
        req.addr = addr;
        request_backlog.push_back(req);
    endtask

    task automatic write_limit(input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 16'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        frame_limit = value & 16'hFFFF;
        limit_writes++;
    endtask

    task automatic wait_idle();
        while (request_backlog.size() != 0 || s_axis_tvalid || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic random_requests(input int unsigned count);
        int unsigned made;
        int unsigned r;
        int unsigned start;
        int unsigned len;

        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                queue_request(MODE_MARK_ALL, $urandom);
                made++;
            end else if (r < 10) begin
                // A run of releases, as software does when it walks a free region.
                start = $urandom_range(0, WINDOW_FRAMES - 1);
                len = $urandom_range(4, 40);
                for (int i = 0; i < len; i++)
                    queue_request(MODE_RELEASE,
                                  (start + i) * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
                made += len;
            end else if (r < 40) begin
                queue_request(MODE_ALLOC, $urandom);
                made++;
            end else if (r < 70) begin
                queue_request(MODE_RELEASE, pick_address());
                made++;
            end else if (r < 90) begin
                queue_request(MODE_RESERVE, pick_address());
                made++;
            end else begin
                queue_request(2'($urandom_range(0, 3)), $urandom);
                made++;
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Request side: a new request is offered only after the previous one was taken.
    always @(negedge clk) begin
        frame_request_t next_req;

        if (rst_n && (!s_axis_tvalid || req_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
                next_req = request_backlog.pop_front();
                s_axis_tuser <= next_req.mode;
                s_axis_tdata <= next_req.addr;
                s_axis_tvalid <= 1'b1;
                send_gap = calm_phase ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random stalls plus one long hold-off on demand.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        frame_reply_t want;
        bit           reply_taken;

        reply_taken = m_axis_tvalid && m_axis_tready;
        if (reply_taken) begin
            if (awaited_replies.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
            end else begin
                want = awaited_replies.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[26:0] !== want.block_address) begin
                    $error("block_address: expected 0x%0h, got 0x%0h",
                           want.block_address, m_axis_tdata[26:0]);
                    errors++;
                end
                if (m_axis_tdata[42:27] !== want.used_count) begin
                    $error("used_count: expected %0d, got %0d",
                           want.used_count, m_axis_tdata[42:27]);
                    errors++;
                end
                if (m_axis_tdata[70:43] !== want.free_bytes) begin
                    $error("free_bytes: expected %0d, got %0d",
                           want.free_bytes, m_axis_tdata[70:43]);
                    errors++;
                end
                status_seen[want.status]++;
                replies_checked++;
            end
        end

        req_taken = s_axis_tvalid && s_axis_tready;
        if (req_taken) begin
            awaited_replies.push_back(apply_request(s_axis_tuser, s_axis_tdata));
            requests_taken++;
            if (s_axis_tuser == MODE_MARK_ALL)
                mark_all_taken++;
        end

        if (req_taken || reply_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("Watchdog: nothing moved for %0d cycles", WATCHDOG_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        foreach (frame_map[i])
            frame_map[i] = '1;
        used_total = NUM_BLOCKS;
        frame_limit = LIMIT_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_limit(LIMIT_RESET);
        queue_request(MODE_ALLOC, 32'h0000_0000);      // every frame used after reset
        queue_request(MODE_RELEASE, 32'h0000_0000);
        queue_request(MODE_RELEASE, 32'h0000_0FFF);    // frame already free
        queue_request(MODE_RELEASE, 32'h07FF_FFFF);    // last frame of the store
        queue_request(MODE_RELEASE, 32'h0800_0000);    // first frame past the store
        queue_request(MODE_RESERVE, 32'hFFFF_FFFF);
        queue_request(MODE_RESERVE, 32'h07FF_F000);
        queue_request(MODE_RESERVE, 32'h07FF_F123);    // frame already used
        queue_request(MODE_RELEASE, 32'h0000_1000);
        queue_request(MODE_RELEASE, 32'h0000_2ABC);
        queue_request(MODE_RELEASE, 32'h0002_0000);    // lone free frame in the second word
        queue_request(MODE_ALLOC, 32'hFFFF_FFFF);
        queue_request(MODE_ALLOC, 32'h0000_0000);
        queue_request(MODE_ALLOC, 32'h0000_0000);
        queue_request(MODE_ALLOC, 32'h0000_0000);      // skips the full first word
        queue_request(MODE_ALLOC, 32'h0000_0000);      // map full again
        queue_request(MODE_RELEASE, 32'h0004_0000);
        queue_request(MODE_MARK_ALL, 32'h5A5A_5A5A);
        queue_request(MODE_ALLOC, 32'h0000_0000);
        wait_idle();

        write_limit(0);
        queue_request(MODE_RELEASE, 32'h0000_5000);
        queue_request(MODE_ALLOC, 32'h0000_0000);      // limit reached though a frame is free
        wait_idle();

        write_limit(16'hFFFF);                         // limit above the store size
        queue_request(MODE_RELEASE, 32'h0000_3000);
        queue_request(MODE_RELEASE, 32'h0000_9ABC);
        queue_request(MODE_ALLOC, 32'h0000_0000);
        queue_request(MODE_ALLOC, 32'h0000_0000);
        wait_idle();

        write_limit(LIMIT_RESET);
        random_requests(210);
        wait_idle();

        // The receiver stops for a long stretch while requests keep coming.
        write_limit($urandom_range(32720, 32767));
        hold_asked++;
        random_requests(210);
        wait_idle();

        write_limit(16'hFFFF);
        random_requests(210);
        wait_idle();

        write_limit($urandom_range(0, 65535));
        calm_phase = 1'b1;
        random_requests(210);
        wait_idle();
        calm_phase = 1'b0;

        write_limit($urandom_range(32700, 32767));
        random_requests(210);
        wait_idle();

        $display("Checked %0d results for %0d requests: %0d done, %0d no free frame, %0d beyond store, %0d no change.",
                 replies_checked, requests_taken, status_seen[ST_DONE], status_seen[ST_NONE_FREE],
                 status_seen[ST_BEYOND], status_seen[ST_SAME]);
        $display("Covered %0d mark-all passes, %0d limit writes and one long receiver hold-off.",
                 mark_all_taken, limit_writes);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
